[hdl/mtt_pkg.sv]
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, widths and constants for the move-toward-target block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

    // default fixed-point fraction width
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int COORD_W = 32;
    localparam int SPEED_W = 24;
    localparam int ET_W    = 16;
    localparam int CELL_W  = 10;

    // internal arithmetic widths
    localparam int MAG_W   = 33;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 33;
    localparam int NUM_W   = 58;
    localparam int DEN_W   = 33;
    localparam int Q_W     = 33;

    // stream widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 120;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_TICK,
        DP_DELTA,
        DP_SQUARE,
        DP_ACC,
        DP_SQRT,
        DP_LEN,
        DP_SNAP,
        DP_MUL,
        DP_DIV,
        DP_STEP,
        DP_CELL,
        DP_CELLST,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic has_goal;
        logic near;
        logic sqrt_busy;
        logic div_busy;
    } t_dp_stat;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DELTA,
        S_SQUARE,
        S_ACC,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_LEN,
        S_DECIDE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_STEP,
        S_CELL_GO,
        S_CELL_WAIT,
        S_CELL_ST,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[hdl/mtt_isqrt.sv]
// ----------------------------------------------------------------------------
// mtt_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_isqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mtt_pkg::SUM_W-1:0]  i_value,
    output logic                            o_busy,
    output logic [mtt_pkg::ROOT_W-1:0]      o_root
);
    import mtt_pkg::*;

    localparam int K_W = $clog2(SUM_W / 2);

    logic             r_busy;
    logic [K_W-1:0]   r_k;
    logic [SUM_W-1:0] r_v;
    logic [SUM_W-1:0] r_res;
    logic [SUM_W-1:0] n_v;
    logic [SUM_W-1:0] n_res;
    logic [SUM_W-1:0] w_bit;
    logic [SUM_W-1:0] w_trial;
    logic             w_ge;

    // one digit of the root per cycle
    always_comb begin
        w_bit   = SUM_W'(1) << {r_k, 1'b0};
        w_trial = r_res + w_bit;
        w_ge    = (r_v >= w_trial);
        n_v     = w_ge ? (r_v - w_trial) : r_v;
        n_res   = w_ge ? ((r_res >> 1) + w_bit) : (r_res >> 1);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_k == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= K_W'(SUM_W / 2 - 1);
            r_v   <= i_value;
            r_res <= '0;
        end else if (r_busy) begin
            r_k   <= r_k - K_W'(1);
            r_v   <= n_v;
            r_res <= n_res;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

`default_nettype wire

[hdl/mtt_div.sv]
// ----------------------------------------------------------------------------
// mtt_div
// Restoring divider, one quotient bit per cycle; the quotient must fit Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mtt_pkg::NUM_W-1:0]  i_num,
    input  wire logic [mtt_pkg::DEN_W-1:0]  i_den,
    output logic                            o_busy,
    output logic [mtt_pkg::Q_W-1:0]         o_quo
);
    import mtt_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quo;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // shift in one dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[Q_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == CNT_W'(1))) begin
            r_busy <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(Q_W);
            r_rem <= DEN_W'(i_num[NUM_W-1:Q_W]);
            r_quo <= i_num[Q_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

[hdl/mtt_datapath.sv]
// ----------------------------------------------------------------------------
// mtt_datapath
// Position, target and speed state with the arithmetic for one move step.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_datapath #(
    parameter int FRAC_BITS = mtt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mtt_pkg::t_dp_cmd              i_cmd,
    output mtt_pkg::t_dp_stat                  o_stat,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mtt_pkg::SPEED_W-1:0]   i_cfg_wr_data,
    input  wire logic [mtt_pkg::S_TDATA_W-1:0] i_tdata,
    output logic [mtt_pkg::M_TDATA_W-1:0]      o_tdata
);
    import mtt_pkg::*;

    localparam logic [ROOT_W-1:0]  NEAR_LSB =
        ROOT_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [COORD_W-1:0] POS_RST   = COORD_W'(64'd48 << FRAC_BITS);
    localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(64'd3 << FRAC_BITS);
    localparam int                 CELL_N_W  = 26;
    localparam int                 CELL_P_W  = 53;
    localparam int                 CELL_RSH  = 33;
    localparam logic [33:0]        HALF_CELL = 34'(64'd50 << FRAC_BITS);
    localparam logic [33:0]        CELL_BIAS = 34'(64'd100 << 17);
    localparam logic [26:0]        CELL_RECIP = 27'd85899346;
    localparam logic [19:0]        CELL_OFS  = 20'(64'd1 << 17);

    // architectural state
    logic [COORD_W-1:0] r_pos [3];
    logic [COORD_W-1:0] r_tgt [3];
    logic               r_goal;
    logic [SPEED_W-1:0] r_speed;

    // per-item working registers
    logic [ET_W-1:0]    r_et;
    logic [SPEED_W-1:0] r_dist;
    logic [MAG_W-1:0]   r_mag [3];
    logic               r_neg [3];
    logic               r_sh;
    logic [SUM_W-1:0]   r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [ROOT_W-1:0]  r_len;
    logic [NUM_W-1:0]   r_prod;
    logic               r_arrived;
    logic [CELL_N_W-1:0] r_cell_n;
    logic [CELL_W-1:0]  r_cell_x;
    logic [CELL_W-1:0]  r_cell_z;
    logic [M_TDATA_W-1:0] r_out;

    // combinational values
    logic [MAG_W-1:0]   w_d   [3];
    logic [MAG_W-1:0]   w_mag [3];
    logic               w_sh;
    logic [31:0]        w_m;
    logic [SUM_W-1:0]   w_sq;
    logic [NUM_W-1:0]   w_prod;
    logic [SPEED_W+ET_W-1:0] w_dist_full;
    logic [ROOT_W-1:0]  w_root;
    logic [ROOT_W-1:0]  w_len;
    logic [33:0]        w_cell_p;
    logic [33:0]        w_cell_a;
    logic [33:0]        w_cell_num;
    logic [CELL_P_W-1:0] w_cell_prod;
    logic [19:0]        w_cell_q;
    logic               w_sqrt_busy;
    logic               w_div_busy;
    logic               w_div_start;
    logic [NUM_W-1:0]   w_div_num;
    logic [DEN_W-1:0]   w_div_den;
    logic [Q_W-1:0]     w_quo;
    logic [COORD_W-1:0] w_step;

    // deltas and magnitudes for all axes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]   = {r_tgt[i][COORD_W-1], r_tgt[i]} - {r_pos[i][COORD_W-1], r_pos[i]};
            w_mag[i] = w_d[i][MAG_W-1] ? (MAG_W'(0) - w_d[i]) : w_d[i];
        end
        w_sh = w_mag[0][MAG_W-1] | w_mag[0][MAG_W-2] |
               w_mag[1][MAG_W-1] | w_mag[1][MAG_W-2] |
               w_mag[2][MAG_W-1] | w_mag[2][MAG_W-2];
    end

    // multiplies and lengths
    always_comb begin
        w_m         = r_sh ? r_mag[i_cmd.axis][MAG_W-1:1] : r_mag[i_cmd.axis][31:0];
        w_sq        = {32'b0, w_m} * {32'b0, w_m};
        w_prod      = NUM_W'(r_mag[i_cmd.axis]) * NUM_W'(r_dist) + NUM_W'(r_len >> 1);
        w_dist_full = (SPEED_W+ET_W)'(r_speed) * (SPEED_W+ET_W)'(r_et);
        w_len       = r_sh ? {w_root[ROOT_W-2:0], 1'b0} : w_root;
    end

    // cell: floor((v + 50) / 100) as a biased unsigned value times 1/100
    always_comb begin
        w_cell_p    = {{2{r_pos[i_cmd.axis][COORD_W-1]}}, r_pos[i_cmd.axis]} + HALF_CELL;
        w_cell_a    = 34'($signed(w_cell_p) >>> FRAC_BITS);
        w_cell_num  = w_cell_a + CELL_BIAS;
        w_cell_prod = CELL_P_W'(r_cell_n) * CELL_P_W'(CELL_RECIP);
        w_cell_q    = w_cell_prod[CELL_P_W-1:CELL_RSH] - CELL_OFS;
    end

    // step divider input
    always_comb begin
        w_div_start = (i_cmd.op == DP_DIV);
        w_div_num   = r_prod;
        w_div_den   = r_len;
        w_step = r_neg[i_cmd.axis] ? (r_pos[i_cmd.axis] - w_quo[COORD_W-1:0])
                                   : (r_pos[i_cmd.axis] + w_quo[COORD_W-1:0]);
    end

    mtt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == DP_SQRT),
        .i_value (r_sum),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    mtt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // speed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RST;
        end else if (i_cfg_wr_en) begin
            r_speed <= i_cfg_wr_data;
        end
    end

    // position, target and goal flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= POS_RST;
            r_pos[1] <= '0;
            r_pos[2] <= POS_RST;
            r_tgt[0] <= '0;
            r_tgt[1] <= '0;
            r_tgt[2] <= '0;
            r_goal   <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_LOAD: begin
                    r_tgt[0] <= i_tdata[31:0];
                    r_tgt[1] <= i_tdata[63:32];
                    r_tgt[2] <= i_tdata[95:64];
                    r_goal   <= 1'b1;
                end
                DP_SNAP: begin
                    r_pos[0] <= r_tgt[0];
                    r_pos[1] <= r_tgt[1];
                    r_pos[2] <= r_tgt[2];
                    r_goal   <= 1'b0;
                end
                DP_STEP: begin
                    r_pos[i_cmd.axis] <= w_step;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_arrived <= 1'b0;
            end
            DP_TICK: begin
                r_et      <= i_tdata[111:96];
                r_arrived <= 1'b0;
            end
            DP_DELTA: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= w_mag[i];
                    r_neg[i] <= w_d[i][MAG_W-1];
                end
                r_sh   <= w_sh;
                r_sum  <= '0;
                r_dist <= w_dist_full[SPEED_W+ET_W-1:16];
            end
            DP_SQUARE: begin
                r_sq <= w_sq;
            end
            DP_ACC: begin
                r_sum <= r_sum + r_sq;
            end
            DP_LEN: begin
                r_len <= w_len;
            end
            DP_SNAP: begin
                r_arrived <= 1'b1;
            end
            DP_MUL: begin
                r_prod <= w_prod;
            end
            DP_CELL: begin
                r_cell_n <= w_cell_num[CELL_N_W-1:0];
            end
            DP_CELLST: begin
                if (i_cmd.axis == AXIS_Z) begin
                    r_cell_z <= w_cell_q[CELL_W-1:0];
                end else begin
                    r_cell_x <= w_cell_q[CELL_W-1:0];
                end
            end
            DP_OUT: begin
                r_out <= {2'b0, r_cell_z, r_cell_x, r_arrived, r_goal,
                          r_pos[2], r_pos[1], r_pos[0]};
            end
            default: begin
            end
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.has_goal  = r_goal;
        o_stat.near      = (r_len < NEAR_LSB) || (ROOT_W'(r_dist) >= r_len);
        o_stat.sqrt_busy = w_sqrt_busy;
        o_stat.div_busy  = w_div_busy;
    end

    assign o_tdata = r_out;

endmodule

`default_nettype wire

[hdl/mtt_ctrl.sv]
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer for one item: deltas, root, per-axis step or snap, cells, result.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_func,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output mtt_pkg::t_dp_cmd       o_cmd,
    input  wire mtt_pkg::t_dp_stat i_stat
);
    import mtt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_axis;
    logic [1:0] n_axis;
    logic       r_out_valid;
    logic       n_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.op    = DP_NOP;
        o_cmd.axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_axis = AXIS_X;
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.op = DP_LOAD;
                        n_state  = S_CELL_GO;
                    end else begin
                        o_cmd.op = DP_TICK;
                        n_state  = i_stat.has_goal ? S_DELTA : S_CELL_GO;
                    end
                end
            end
            S_DELTA: begin
                o_cmd.op = DP_DELTA;
                n_state  = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.op = DP_SQUARE;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = DP_ACC;
                if (r_axis == AXIS_Z) begin
                    n_axis  = AXIS_X;
                    n_state = S_SQRT_GO;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_SQUARE;
                end
            end
            S_SQRT_GO: begin
                o_cmd.op = DP_SQRT;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (!i_stat.sqrt_busy) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.op = DP_LEN;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                n_axis = AXIS_X;
                if (i_stat.near) begin
                    o_cmd.op = DP_SNAP;
                    n_state  = S_CELL_GO;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = DP_MUL;
                n_state  = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.op = DP_DIV;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.op = DP_STEP;
                if (r_axis == AXIS_Z) begin
                    n_axis  = AXIS_X;
                    n_state = S_CELL_GO;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_CELL_GO: begin
                o_cmd.op = DP_CELL;
                n_state  = S_CELL_WAIT;
            end
            S_CELL_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_CELL_ST;
                end
            end
            S_CELL_ST: begin
                o_cmd.op = DP_CELLST;
                if (r_axis == AXIS_Z) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = AXIS_Z;
                    n_state = S_CELL_GO;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hdl/move_toward_target_3d.sv]
// ----------------------------------------------------------------------------
// move_toward_target_3d
// One mover stepping toward a 3D target at a fixed speed, fixed-point.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A load item, or a tick with no goal, runs
// two ground cell passes, each a multiply by the reciprocal of 100, plus
// accept and output. A tick with a goal either snaps onto the target or
// steps: the square root wait, then one multiply and divide pass per axis on
// a single divider. The next item is accepted while the previous result still
// waits on the output register; a result only stalls the block when the one
// before it has not been taken yet.
`default_nettype none

module move_toward_target_3d #(
    parameter int FRAC_BITS = mtt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // speed_per_second
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mtt_pkg::SPEED_W-1:0]   i_cfg_wr_data,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // target_x, target_y, target_z, elapsed_time
    input  wire logic [mtt_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // func
    input  wire logic                          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // pos_x, pos_y, pos_z, moving, arrived, cell_x, cell_z, zero pad
    output logic [mtt_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import mtt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_func      (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mtt_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tdata       (i_s_axis_tdata),
        .o_tdata       (o_m_axis_tdata)
    );

    // an accepted transaction always starts work, so ready drops next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready stayed high after a transaction");

    // a snap clears the goal, so moving and arrived never show together
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[96] && o_m_axis_tdata[97]))
        else $error("moving and arrived both set");

endmodule

`default_nettype wire
